/* sv/are_pkg.sv */
package are_pkg;

    localparam int NUM_REGS = 8;
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam logic [7:0] MASK_LO_NIB = 8'h0F;
    localparam logic [7:0] MASK_HI_NIB = 8'hF0;
    localparam logic [7:0] MASK_BYTE   = 8'hFF;
    localparam logic [7:0] BIT7        = 8'h80;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_ADDC = 4'd1,
        OP_AND  = 4'd2,
        OP_OR   = 4'd3,
        OP_XOR  = 4'd4,
        OP_MUL  = 4'd5,
        OP_MOV  = 4'd6,
        OP_INV  = 4'd7,
        OP_SWAP = 4'd8,
        OP_LSR  = 4'd9,
        OP_LSRC = 4'd10,
        OP_CMP  = 4'd11,
        OP_CMPC = 4'd12
    } t_op;

    // 3-bit register field wrapped into the file depth
    function automatic t_idx reg_idx(input logic [2:0] v);
        logic [4:0] t;
        t = {2'b00, v};
        for (int k = 0; k < 3; k++) begin
            if (t >= 5'(NUM_REGS)) begin
                t = t - 5'(NUM_REGS);
            end
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

/* sv/are_if.sv */
interface are_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic [2:0] dst_reg;
    logic [2:0] src_reg;
    logic       use_const;
    logic [7:0] imm_byte;
    logic       clear_high_nibble;
    logic       clear_low_nibble;
    logic       invert_high_nibble;
    logic       invert_low_nibble;
    logic       force_carry_in;
    logic [2:0] high_dst_reg;

    modport source (
        output valid, op, dst_reg, src_reg, use_const, imm_byte, clear_high_nibble,
               clear_low_nibble, invert_high_nibble, invert_low_nibble, force_carry_in,
               high_dst_reg,
        input  ready
    );
    modport sink (
        input  valid, op, dst_reg, src_reg, use_const, imm_byte, clear_high_nibble,
               clear_low_nibble, invert_high_nibble, invert_low_nibble, force_carry_in,
               high_dst_reg,
        output ready
    );
endinterface

interface are_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] written_value;
    logic [7:0] written_high;
    logic       reg_written;
    logic       carry_flag;
    logic       zero_flag;
    logic       less_flag;
    logic       equal_flag;
    logic       greater_flag;

    modport source (
        output valid, written_value, written_high, reg_written, carry_flag, zero_flag,
               less_flag, equal_flag, greater_flag,
        input  ready
    );
    modport sink (
        input  valid, written_value, written_high, reg_written, carry_flag, zero_flag,
               less_flag, equal_flag, greater_flag,
        output ready
    );
endinterface

/* sv/alu_register_execute.sv */
// Requests pass the operand stage (operand read), then execute into the result register.
// Throughput: one request per cycle while the output is not stalled; the execute
// stage writes the register file and flags at the same edge the result register
// loads, with write-to-read bypass.
// Reset (synchronous, active low): register file reads as zero, all flags cleared,
// both pipeline stages empty.
module alu_register_execute (
    input  logic      i_clk,
    input  logic      i_rst_n,
    are_in_if.sink    i_in,
    are_out_if.source o_out
);

    // operand stage
    logic               r_s1_valid;
    logic [3:0]         r_op;
    are_pkg::t_idx      r_dst;
    are_pkg::t_idx      r_hd;
    logic               r_use_const;
    logic [7:0]         r_imm;
    logic               r_clr_hi;
    logic               r_clr_lo;
    logic               r_inv_hi;
    logic               r_inv_lo;
    logic               r_force_c;
    logic [7:0]         r_dv_mem;
    logic [7:0]         r_sv_mem;
    logic               r_dv_ok;
    logic               r_sv_ok;
    logic               r_dv_byp_en;
    logic               r_sv_byp_en;
    logic [7:0]         r_dv_byp;
    logic [7:0]         r_sv_byp;

    // architectural state
    logic [7:0]              r_rf [are_pkg::NUM_REGS];
    logic [are_pkg::NUM_REGS-1:0] r_rf_ok;
    logic [are_pkg::NUM_REGS-1:0] n_rf_ok;
    logic r_carry, r_zero, r_less, r_equal, r_greater;

    // result register
    logic       r_out_valid;
    logic [7:0] r_wv;
    logic [7:0] r_wh;
    logic       r_rw;
    logic       r_oc, r_oz, r_ol, r_oe, r_og;

    logic          w_adv;
    logic          w_in_acc;
    are_pkg::t_idx w_in_d;
    are_pkg::t_idx w_in_s;
    logic          w_wr_lo;
    logic          w_wr_hi;

    logic [7:0]  w_dv;
    logic [7:0]  w_rs;
    logic [7:0]  w_raw;
    logic [7:0]  w_sv;
    logic [8:0]  w_sum;
    logic [15:0] w_prod;
    logic        w_cin;
    logic [7:0]  w_res;
    logic [7:0]  w_hi;
    logic        w_wr;
    logic        w_is_mul;
    logic        n_carry, n_zero, n_less, n_equal, n_greater;
    logic        w_fwd_d_en, w_fwd_s_en;
    logic [7:0]  w_fwd_d, w_fwd_s;

    function automatic logic op_is_addc(input logic [3:0] op);
        return are_pkg::t_op'(op) == are_pkg::OP_ADDC;
    endfunction

    assign w_adv    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_in_d   = are_pkg::reg_idx(i_in.dst_reg);
    assign w_in_s   = are_pkg::reg_idx(i_in.src_reg);
    assign w_wr_lo  = w_adv && w_wr;
    assign w_wr_hi  = w_adv && w_is_mul;

    // bypass of the writes landing at this edge; the high byte is written last
    always_comb begin
        w_fwd_d_en = 1'b0;
        w_fwd_d    = w_res;
        if (w_wr_hi && r_hd == w_in_d) begin
            w_fwd_d_en = 1'b1;
            w_fwd_d    = w_hi;
        end else if (w_wr_lo && r_dst == w_in_d) begin
            w_fwd_d_en = 1'b1;
        end
        w_fwd_s_en = 1'b0;
        w_fwd_s    = w_res;
        if (w_wr_hi && r_hd == w_in_s) begin
            w_fwd_s_en = 1'b1;
            w_fwd_s    = w_hi;
        end else if (w_wr_lo && r_dst == w_in_s) begin
            w_fwd_s_en = 1'b1;
        end
    end

    always_comb begin
        w_dv  = r_dv_byp_en ? r_dv_byp : (r_dv_ok ? r_dv_mem : '0);
        w_rs  = r_sv_byp_en ? r_sv_byp : (r_sv_ok ? r_sv_mem : '0);
        w_raw = r_use_const ? r_imm : w_rs;
        w_sv  = w_raw;
        if (!r_use_const) begin
            if (r_clr_hi) w_sv = w_sv & are_pkg::MASK_LO_NIB;
            if (r_clr_lo) w_sv = w_sv & are_pkg::MASK_HI_NIB;
            if (r_inv_hi) w_sv = w_sv ^ are_pkg::MASK_HI_NIB;
            if (r_inv_lo) w_sv = w_sv ^ are_pkg::MASK_LO_NIB;
        end

        w_cin  = (op_is_addc(r_op)) && (r_carry || r_force_c);
        w_sum  = {1'b0, w_dv} + {1'b0, w_sv} + {8'd0, w_cin};
        w_prod = {8'd0, w_dv} * {8'd0, w_sv};

        w_res     = '0;
        w_hi      = '0;
        w_wr      = 1'b0;
        w_is_mul  = 1'b0;
        n_carry   = r_carry;
        n_zero    = r_zero;
        n_less    = r_less;
        n_equal   = r_equal;
        n_greater = r_greater;

        unique case (are_pkg::t_op'(r_op))
            are_pkg::OP_ADD, are_pkg::OP_ADDC: begin
                w_res   = w_sum[7:0];
                n_carry = w_sum[8];
                n_zero  = (w_sum[7:0] == 8'd0);
                w_wr    = 1'b1;
            end
            are_pkg::OP_AND, are_pkg::OP_OR, are_pkg::OP_XOR: begin
                if (are_pkg::t_op'(r_op) == are_pkg::OP_AND) w_res = w_dv & w_sv;
                else if (are_pkg::t_op'(r_op) == are_pkg::OP_OR) w_res = w_dv | w_sv;
                else w_res = w_dv ^ w_sv;
                n_carry = 1'b0;
                n_zero  = (w_res == 8'd0);
                w_wr    = 1'b1;
            end
            are_pkg::OP_MUL: begin
                w_res    = w_prod[7:0];
                w_hi     = w_prod[15:8];
                n_carry  = 1'b0;
                n_zero   = (w_prod == 16'd0);
                w_wr     = 1'b1;
                w_is_mul = 1'b1;
            end
            are_pkg::OP_MOV: begin
                w_res = w_sv;
                w_wr  = 1'b1;
            end
            are_pkg::OP_INV: begin
                w_res = w_dv ^ are_pkg::MASK_BYTE;
                w_wr  = 1'b1;
            end
            are_pkg::OP_SWAP: begin
                w_res = {w_dv[3:0], w_dv[7:4]};
                w_wr  = 1'b1;
            end
            are_pkg::OP_LSR, are_pkg::OP_LSRC: begin
                w_res = {1'b0, w_dv[7:1]};
                if (are_pkg::t_op'(r_op) == are_pkg::OP_LSRC && r_carry) begin
                    w_res = w_res | are_pkg::BIT7;
                end
                n_carry = w_dv[0];
                w_wr    = 1'b1;
            end
            are_pkg::OP_CMP, are_pkg::OP_CMPC: begin
                // chained compare acts only while equal is set
                if (are_pkg::t_op'(r_op) == are_pkg::OP_CMP || r_equal) begin
                    n_less    = (w_dv < w_raw);
                    n_equal   = (w_dv == w_raw);
                    n_greater = (w_dv > w_raw);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rf_ok = r_rf_ok;
        if (w_wr)     n_rf_ok[r_dst] = 1'b1;
        if (w_is_mul) n_rf_ok[r_hd]  = 1'b1;
    end

    // register file: two write ports (mul), two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_wr_lo && !(w_wr_hi && r_hd == r_dst)) r_rf[r_dst] <= w_res;
        if (w_wr_hi) r_rf[r_hd]  <= w_hi;
        if (w_in_acc) begin
            r_dv_mem <= r_rf[w_in_d];
            r_sv_mem <= r_rf[w_in_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_ok   <= '0;
            r_carry   <= 1'b0;
            r_zero    <= 1'b0;
            r_less    <= 1'b0;
            r_equal   <= 1'b0;
            r_greater <= 1'b0;
        end else if (w_adv) begin
            r_rf_ok   <= n_rf_ok;
            r_carry   <= n_carry;
            r_zero    <= n_zero;
            r_less    <= n_less;
            r_equal   <= n_equal;
            r_greater <= n_greater;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op        <= i_in.op;
            r_dst       <= w_in_d;
            r_hd        <= are_pkg::reg_idx(i_in.high_dst_reg);
            r_use_const <= i_in.use_const;
            r_imm       <= i_in.imm_byte;
            r_clr_hi    <= i_in.clear_high_nibble;
            r_clr_lo    <= i_in.clear_low_nibble;
            r_inv_hi    <= i_in.invert_high_nibble;
            r_inv_lo    <= i_in.invert_low_nibble;
            r_force_c   <= i_in.force_carry_in;
            r_dv_ok     <= r_rf_ok[w_in_d];
            r_sv_ok     <= r_rf_ok[w_in_s];
            r_dv_byp_en <= w_fwd_d_en;
            r_sv_byp_en <= w_fwd_s_en;
            r_dv_byp    <= w_fwd_d;
            r_sv_byp    <= w_fwd_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wv <= w_res;
            r_wh <= w_hi;
            r_rw <= w_wr;
            r_oc <= n_carry;
            r_oz <= n_zero;
            r_ol <= n_less;
            r_oe <= n_equal;
            r_og <= n_greater;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.written_value = r_wv;
    assign o_out.written_high  = r_wh;
    assign o_out.reg_written   = r_rw;
    assign o_out.carry_flag    = r_oc;
    assign o_out.zero_flag     = r_oz;
    assign o_out.less_flag     = r_ol;
    assign o_out.equal_flag    = r_oe;
    assign o_out.greater_flag  = r_og;

    a_rel_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_less, r_equal, r_greater}))
        else $error("more than one compare relation flag set");

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_rw) |-> (r_wv == 8'd0 && r_wh == 8'd0))
        else $error("result bytes nonzero without a register write");

    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable({r_carry, r_zero, r_less, r_equal, r_greater}))
        else $error("flags changed without an executed request");

endmodule
